FILE: rtl/dsbf_pkg.sv
// Package for the DNS section boundary finder: transaction payload types,
// parse state, section/phase/status codes and the size limit.
// No dependencies.
package dsbf_pkg;

	localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd65535;
	localparam logic [15:0] HEADER_BYTES      = 16'd12;
	localparam logic [7:0]  PTR_MASK          = 8'hc0;

	localparam logic [2:0] SEC_HEADER     = 3'd0;
	localparam logic [2:0] SEC_QUESTION   = 3'd1;
	localparam logic [2:0] SEC_ADDITIONAL = 3'd4;
	localparam logic [2:0] SEC_TRAILING   = 3'd5;

	localparam logic [1:0] STATUS_NOT_LAST  = 2'd0;
	localparam logic [1:0] STATUS_OK        = 2'd1;
	localparam logic [1:0] STATUS_SHORT     = 2'd2;
	localparam logic [1:0] STATUS_MALFORMED = 2'd3;

	typedef enum logic [2:0] {
		PH_NAME_LEN = 3'd0,
		PH_LABEL    = 3'd1,
		PH_PTR_LO   = 3'd2,
		PH_FIXED    = 3'd3,
		PH_RDLEN_HI = 3'd4,
		PH_RDLEN_LO = 3'd5,
		PH_RDATA    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  section_tag;
		logic        is_last;
		logic [1:0]  status;
		logic [15:0] answers_offset;
		logic [15:0] authority_offset;
		logic [15:0] additional_offset;
	} result_t;

	typedef struct packed {
		logic [15:0]      pos;
		logic [2:0]       sec;
		phase_t           phase;
		logic [15:0]      skip;
		logic [15:0]      left;
		logic [3:0][15:0] counts;
		logic [2:0][15:0] starts;
		logic [7:0]       len_hi;
		logic             err;
	} state_t;

	localparam state_t STATE_RESET = '0;

endpackage

FILE: rtl/dsbf_step.sv
// Per-byte parse step of the DNS section boundary finder: next parse state
// and the result for one message byte. Purely combinational.
// Depends on dsbf_pkg.
module dsbf_step (
	input  dsbf_pkg::state_t  st,
	input  dsbf_pkg::item_t   item,
	output dsbf_pkg::state_t  st_next,
	output dsbf_pkg::result_t res
);

	// Go to the next section with entries, else to the trailing one.
	function automatic dsbf_pkg::state_t advance(input dsbf_pkg::state_t s_in,
			input logic [15:0] off);
		dsbf_pkg::state_t s;
		logic found;
		s = s_in;
		found = 1'b0;
		for (int k = 1; k <= 4; k++) begin
			if (!found && k > int'(s_in.sec)) begin
				if (k >= 2) s.starts[2'(k - 2)] = off;
				if (s_in.counts[2'(k - 1)] != '0) begin
					found = 1'b1;
					s.left = s_in.counts[2'(k - 1)];
					s.sec = 3'(k);
					s.phase = dsbf_pkg::PH_NAME_LEN;
				end
			end
		end
		if (!found) s.sec = dsbf_pkg::SEC_TRAILING;
		return s;
	endfunction

	function automatic dsbf_pkg::state_t entry_done(input dsbf_pkg::state_t s_in,
			input logic [15:0] off);
		dsbf_pkg::state_t s;
		s = s_in;
		s.phase = dsbf_pkg::PH_NAME_LEN;
		s.left = s_in.left - 16'd1;
		if (s.left == '0) s = advance(s, off);
		return s;
	endfunction

	function automatic dsbf_pkg::state_t name_done(input dsbf_pkg::state_t s_in);
		dsbf_pkg::state_t s;
		s = s_in;
		s.phase = dsbf_pkg::PH_FIXED;
		s.skip = (s_in.sec == dsbf_pkg::SEC_QUESTION) ? 16'd4 : 16'd8;
		return s;
	endfunction

	dsbf_pkg::state_t ns;
	logic [15:0] noff;
	logic [15:0] p;
	logic [1:0]  cidx;
	logic [7:0]  b;

	always_comb begin
		ns = st;
		b = item.data_byte;
		p = st.pos;
		noff = 16'(st.pos + 16'd1 - dsbf_pkg::HEADER_BYTES);
		cidx = 2'((p[3:0] - 4'd4) >> 1);
		if (st.pos >= dsbf_pkg::MAX_MESSAGE_BYTES) begin
			ns.err = 1'b1;
		end else if (!st.err) begin
			ns.pos = p + 16'd1;
			if (p < dsbf_pkg::HEADER_BYTES) begin
				if (p >= 16'd4) begin
					if (!p[0]) ns.counts[cidx] = {b, 8'h00};
					else ns.counts[cidx] = st.counts[cidx] | {8'h00, b};
				end
				if (p == dsbf_pkg::HEADER_BYTES - 16'd1) ns = advance(ns, 16'd0);
			end else if (st.sec >= dsbf_pkg::SEC_QUESTION &&
					st.sec <= dsbf_pkg::SEC_ADDITIONAL) begin
				unique case (st.phase)
					dsbf_pkg::PH_NAME_LEN: begin
						if (b == 8'h00) begin
							ns = name_done(ns);
						end else if ((b & dsbf_pkg::PTR_MASK) != 8'h00) begin
							ns.phase = dsbf_pkg::PH_PTR_LO;
						end else begin
							ns.phase = dsbf_pkg::PH_LABEL;
							ns.skip = {8'h00, b};
						end
					end
					dsbf_pkg::PH_LABEL: begin
						ns.skip = st.skip - 16'd1;
						if (ns.skip == '0) ns.phase = dsbf_pkg::PH_NAME_LEN;
					end
					dsbf_pkg::PH_PTR_LO: begin
						ns = name_done(ns);
					end
					dsbf_pkg::PH_FIXED: begin
						ns.skip = st.skip - 16'd1;
						if (ns.skip == '0) begin
							if (st.sec == dsbf_pkg::SEC_QUESTION) ns = entry_done(ns, noff);
							else ns.phase = dsbf_pkg::PH_RDLEN_HI;
						end
					end
					dsbf_pkg::PH_RDLEN_HI: begin
						ns.len_hi = b;
						ns.phase = dsbf_pkg::PH_RDLEN_LO;
					end
					dsbf_pkg::PH_RDLEN_LO: begin
						ns.skip = {st.len_hi, b};
						if (ns.skip == '0) ns = entry_done(ns, noff);
						else ns.phase = dsbf_pkg::PH_RDATA;
					end
					default: begin
						ns.skip = st.skip - 16'd1;
						if (ns.skip == '0) ns = entry_done(ns, noff);
					end
				endcase
			end
		end

		res.section_tag = st.sec;
		res.is_last = item.last_byte;
		res.status = dsbf_pkg::STATUS_NOT_LAST;
		res.answers_offset = '0;
		res.authority_offset = '0;
		res.additional_offset = '0;
		if (item.last_byte) begin
			if (ns.pos < dsbf_pkg::HEADER_BYTES && !ns.err) begin
				res.status = dsbf_pkg::STATUS_SHORT;
			end else if (ns.err) begin
				res.status = dsbf_pkg::STATUS_MALFORMED;
			end else if (ns.pos == dsbf_pkg::HEADER_BYTES) begin
				res.status = dsbf_pkg::STATUS_OK;
			end else if (ns.sec == dsbf_pkg::SEC_TRAILING) begin
				res.status = dsbf_pkg::STATUS_OK;
				res.answers_offset = ns.starts[0];
				res.authority_offset = ns.starts[1];
				res.additional_offset = ns.starts[2];
			end else begin
				res.status = dsbf_pkg::STATUS_MALFORMED;
			end
		end

		// The message ends here, so the next byte starts a fresh header.
		st_next = item.last_byte ? dsbf_pkg::STATE_RESET : ns;
	end

endmodule

FILE: rtl/dns_section_boundary_finder.sv
// A byte accepted into the input register moves its result into the output
// register as it leaves. Throughput: one byte per cycle while result_ready is high.
// The input register, the parse step and the result register form a two-stage
// pipeline; the parse state updates when a byte leaves the input register.
// Reset (arst_n low, asynchronous) clears the parse state and both valid flags.
// Depends on dsbf_pkg and dsbf_step.
module dns_section_boundary_finder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  dsbf_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_ready,
	output dsbf_pkg::result_t  result
);

	logic              item_valid_s1;
	dsbf_pkg::item_t   item_s1;
	logic              result_valid_s2;
	dsbf_pkg::result_t result_s2;
	dsbf_pkg::state_t  state_q;
	dsbf_pkg::state_t  state_next;
	dsbf_pkg::result_t step_res;
	logic              step_go;

	assign step_go = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || step_go;

	dsbf_step u_step (
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			result_valid_s2 <= 1'b0;
			state_q <= dsbf_pkg::STATE_RESET;
		end else begin
			if (item_ready) item_valid_s1 <= item_valid;
			if (step_go) begin
				result_valid_s2 <= 1'b1;
				state_q <= state_next;
			end else if (result_ready) begin
				result_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_s1 <= item;
		if (step_go) result_s2 <= step_res;
	end

	assign result_valid = result_valid_s2;
	assign result = result_s2;

endmodule

FILE: rtl/dsbf_checker.sv
// Port-level checker for the DNS section boundary finder, bound to the top level.
// Depends on dsbf_pkg and dns_section_boundary_finder.
module dsbf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input dsbf_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input dsbf_pkg::result_t result
);

	// A stalled result transaction must stay offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_not_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_last |->
			result.status == dsbf_pkg::STATUS_NOT_LAST &&
			result.answers_offset == '0 && result.authority_offset == '0 &&
			result.additional_offset == '0)
		else $error("status or offsets set on a byte that is not last");

	a_fail_no_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_last && result.status != dsbf_pkg::STATUS_OK |->
			result.answers_offset == '0 && result.authority_offset == '0 &&
			result.additional_offset == '0)
		else $error("offsets reported without ok status");

	a_offsets_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_last && result.status == dsbf_pkg::STATUS_OK |->
			result.answers_offset <= result.authority_offset &&
			result.authority_offset <= result.additional_offset)
		else $error("section offsets out of order");

endmodule

bind dns_section_boundary_finder dsbf_checker u_dsbf_checker (.*);
